### sv/gf256_matrix_row_engine_macros.svh
// Assertion macros used by the GF(256) matrix row engine controller.
// No dependencies; included by files that carry assertions.
`ifndef GF256_MATRIX_ROW_ENGINE_MACROS_SVH
`define GF256_MATRIX_ROW_ENGINE_MACROS_SVH

// Implication checked on every rising clock edge while out of reset.
`define GMR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked while out of reset.
`define GMR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/gmr_pkg.sv
// Package for the GF(256) matrix row engine: sizes, action codes, command types.
// No dependencies.
package gmr_pkg;

  localparam int MaxRows = 64;
  localparam int MaxCols = 64;
  localparam int RowW = $clog2(MaxRows);
  localparam int ColW = $clog2(MaxCols);
  localparam int AddrW = RowW + ColW;
  localparam int Depth = MaxRows * MaxCols;
  localparam int CntW = 7;

  localparam logic [3:0] ActWrite = 4'd0;
  localparam logic [3:0] ActRead = 4'd1;
  localparam logic [3:0] ActCopy = 4'd2;
  localparam logic [3:0] ActSwapRows = 4'd3;
  localparam logic [3:0] ActSwapCols = 4'd4;
  localparam logic [3:0] ActAxpy = 4'd5;
  localparam logic [3:0] ActAdd = 4'd6;
  localparam logic [3:0] ActScale = 4'd7;
  localparam logic [3:0] ActZero = 4'd8;

  localparam logic [1:0] RegCols = 2'd0;
  localparam logic [1:0] RegRows = 2'd1;
  localparam logic [1:0] RegPoly = 2'd2;

  // Write data selection in the datapath.
  typedef enum logic [2:0] {
    WSEL_VALUE = 3'd0,
    WSEL_RDA   = 3'd1,
    WSEL_HOLD  = 3'd2,
    WSEL_XOR   = 3'd3,
    WSEL_AXPY  = 3'd4,
    WSEL_SCALE = 3'd5,
    WSEL_ZERO  = 3'd6
  } wsel_t;

  // Controller to datapath command.
  typedef struct packed {
    logic [AddrW-1:0] raddr_a;
    logic [AddrW-1:0] raddr_b;
    logic             wen;
    logic [AddrW-1:0] waddr;
    wsel_t            wsel;
    logic             hold_load;
    logic             rd_capture;
  } dp_cmd_t;

  // Shift-add GF(256) product, one dependent step per bit of b.
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] poly);
    logic [7:0] acc;
    logic [7:0] x;
    acc = 8'h00;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc = acc ^ x;
      x = x[7] ? ({x[6:0], 1'b0} ^ poly) : {x[6:0], 1'b0};
    end
    return acc;
  endfunction

endpackage

### sv/gmr_ram.sv
// Generic dual-read, single-write RAM with registered read data.
// No dependencies.
module gmr_ram #(
  parameter int Width = 8,
  parameter int Depth = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr_a,
  input  logic [$clog2(Depth)-1:0] raddr_b,
  output logic [Width-1:0]         rdata_a,
  output logic [Width-1:0]         rdata_b
);

  logic [Width-1:0] mem [Depth];

  // Write port and two registered read ports.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

### sv/gmr_datapath.sv
// Datapath: matrix memory, GF(256) multiplier and write-data selection.
// Depends on gmr_pkg and gmr_ram.
module gmr_datapath (
  input  logic            clk,
  input  gmr_pkg::dp_cmd_t cmd,
  input  logic [7:0]      value,
  input  logic [7:0]      poly,
  output logic [7:0]      read_data
);

  logic [7:0] rda;
  logic [7:0] rdb;
  logic [7:0] wdata;
  logic [7:0] hold_r;
  logic [7:0] hold_nxt;
  logic [7:0] rd_r;
  logic [7:0] rd_nxt;

  gmr_ram #(.Width(8), .Depth(gmr_pkg::Depth)) u_ram (
    .clk(clk), .we(cmd.wen), .waddr(cmd.waddr), .wdata(wdata),
    .raddr_a(cmd.raddr_a), .raddr_b(cmd.raddr_b), .rdata_a(rda), .rdata_b(rdb)
  );

  // Select the octet written this cycle; port A reads the source, B the destination.
  always_comb begin
    case (cmd.wsel)
      gmr_pkg::WSEL_VALUE: wdata = value;
      gmr_pkg::WSEL_RDA:   wdata = rda;
      gmr_pkg::WSEL_HOLD:  wdata = hold_r;
      gmr_pkg::WSEL_XOR:   wdata = rda ^ rdb;
      gmr_pkg::WSEL_AXPY:  wdata = rdb ^ gmr_pkg::gf_mul(value, rda, poly);
      gmr_pkg::WSEL_SCALE: wdata = gmr_pkg::gf_mul(value, rdb, poly);
      default:             wdata = 8'h00;
    endcase
  end

  // Swap holding register and read result capture.
  always_comb begin
    hold_nxt = cmd.hold_load ? rdb : hold_r;
    rd_nxt = cmd.rd_capture ? rdb : rd_r;
  end

  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
    rd_r <= rd_nxt;
  end

  assign read_data = rd_r;

endmodule

### sv/gmr_ctrl.sv
// Controller: sequences memory accesses for one action and raises the done strobe.
// Depends on gmr_pkg and the assertion macro header.
`include "gf256_matrix_row_engine_macros.svh"
module gmr_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [3:0]                   action,
  input  logic [gmr_pkg::RowW-1:0]     dst_row,
  input  logic [gmr_pkg::RowW-1:0]     src_row,
  input  logic [gmr_pkg::ColW-1:0]     col_first,
  input  logic [gmr_pkg::ColW-1:0]     col_second,
  input  logic [7:0]                   value,
  input  logic [gmr_pkg::CntW-1:0]     active_cols,
  input  logic [gmr_pkg::CntW-1:0]     active_rows,
  output logic                         busy,
  output logic                         done,
  output logic [3:0]                   done_action,
  output logic                         out_zero,
  output gmr_pkg::dp_cmd_t             cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RUN  = 5'b00010,
    S_SWB  = 5'b00100,
    S_LAST = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  localparam int IdxW = gmr_pkg::CntW;

  state_t state_r, state_nxt;
  logic [3:0] act_r, act_nxt;
  logic [gmr_pkg::RowW-1:0] dr_r, dr_nxt, sr_r, sr_nxt;
  logic [gmr_pkg::ColW-1:0] c1_r, c1_nxt, c2_r, c2_nxt;
  logic [IdxW-1:0] idx_r, idx_nxt;
  logic [IdxW-1:0] lim_r, lim_nxt;
  logic pend_r, pend_nxt;
  logic [IdxW-1:0] pidx_r, pidx_nxt;
  logic [IdxW-1:0] cols_sat, rows_sat;
  logic is_row_op, is_skip;
  logic [gmr_pkg::RowW-1:0] idx_row, pidx_row;
  logic [gmr_pkg::ColW-1:0] idx_col, pidx_col;

  // Saturate the active counts to the matrix size.
  assign cols_sat = (active_cols > IdxW'(gmr_pkg::MaxCols)) ? IdxW'(gmr_pkg::MaxCols)
                                                              : active_cols;
  assign rows_sat = (active_rows > IdxW'(gmr_pkg::MaxRows)) ? IdxW'(gmr_pkg::MaxRows)
                                                              : active_rows;
  assign idx_row = idx_r[gmr_pkg::RowW-1:0];
  assign idx_col = idx_r[gmr_pkg::ColW-1:0];
  assign pidx_row = pidx_r[gmr_pkg::RowW-1:0];
  assign pidx_col = pidx_r[gmr_pkg::ColW-1:0];

  // Row walks read column idx and write column pidx in the cycle after.
  assign is_row_op = (action == gmr_pkg::ActCopy) || (action == gmr_pkg::ActAxpy) ||
                     (action == gmr_pkg::ActAdd) || (action == gmr_pkg::ActScale) ||
                     (action == gmr_pkg::ActZero) || (action == gmr_pkg::ActSwapRows) ||
                     (action == gmr_pkg::ActSwapCols);
  assign is_skip = ((action == gmr_pkg::ActSwapRows) && (dst_row == src_row)) ||
                   ((action == gmr_pkg::ActSwapCols) && (col_first == col_second)) ||
                   (((action == gmr_pkg::ActAxpy) || (action == gmr_pkg::ActScale)) &&
                    (value == 8'h00));

  // Next-state and command logic.
  always_comb begin
    state_nxt = state_r;
    act_nxt = act_r;
    dr_nxt = dr_r;
    sr_nxt = sr_r;
    c1_nxt = c1_r;
    c2_nxt = c2_r;
    idx_nxt = idx_r;
    lim_nxt = lim_r;
    pend_nxt = 1'b0;
    pidx_nxt = idx_r;
    cmd = '0;
    cmd.wsel = gmr_pkg::WSEL_ZERO;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          act_nxt = action;
          dr_nxt = dst_row;
          sr_nxt = src_row;
          c1_nxt = col_first;
          c2_nxt = col_second;
          idx_nxt = '0;
          lim_nxt = (action == gmr_pkg::ActSwapCols) ? rows_sat : cols_sat;
          if (action == gmr_pkg::ActWrite) begin
            cmd.wen = 1'b1;
            cmd.waddr = {dst_row, col_first};
            cmd.wsel = gmr_pkg::WSEL_VALUE;
            state_nxt = S_DONE;
          end else if (action == gmr_pkg::ActRead) begin
            cmd.raddr_b = {dst_row, col_first};
            state_nxt = S_LAST;
          end else if (is_row_op && !is_skip) begin
            state_nxt = S_RUN;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_RUN: begin
        // Write back the element read in the previous cycle.
        if (pend_r) begin
          cmd.wen = 1'b1;
          case (act_r)
            gmr_pkg::ActCopy:  begin cmd.waddr = {dr_r, pidx_col}; cmd.wsel = gmr_pkg::WSEL_RDA; end
            gmr_pkg::ActAdd:   begin cmd.waddr = {dr_r, pidx_col}; cmd.wsel = gmr_pkg::WSEL_XOR; end
            gmr_pkg::ActAxpy:  begin cmd.waddr = {dr_r, pidx_col}; cmd.wsel = gmr_pkg::WSEL_AXPY; end
            gmr_pkg::ActScale: begin cmd.waddr = {dr_r, pidx_col}; cmd.wsel = gmr_pkg::WSEL_SCALE; end
            gmr_pkg::ActZero:  begin cmd.waddr = {dr_r, pidx_col}; cmd.wsel = gmr_pkg::WSEL_ZERO; end
            gmr_pkg::ActSwapRows: begin
              cmd.waddr = {dr_r, pidx_col};
              cmd.wsel = gmr_pkg::WSEL_RDA;
              cmd.hold_load = 1'b1;
            end
            gmr_pkg::ActSwapCols: begin
              cmd.waddr = {pidx_row, c1_r};
              cmd.wsel = gmr_pkg::WSEL_RDA;
              cmd.hold_load = 1'b1;
            end
            default: cmd.wen = 1'b0;
          endcase
        end
        if ((act_r == gmr_pkg::ActSwapRows || act_r == gmr_pkg::ActSwapCols) && pend_r) begin
          // Swaps need a second write slot for the held destination octet.
          state_nxt = S_SWB;
          pidx_nxt = pidx_r;
        end else if (idx_r >= lim_r) begin
          state_nxt = S_DONE;
        end else begin
          // Issue reads for the next element.
          if (act_r == gmr_pkg::ActSwapCols) begin
            cmd.raddr_a = {idx_row, c2_r};
            cmd.raddr_b = {idx_row, c1_r};
          end else begin
            cmd.raddr_a = {sr_r, idx_col};
            cmd.raddr_b = {dr_r, idx_col};
          end
          pend_nxt = 1'b1;
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_SWB: begin
        cmd.wen = 1'b1;
        cmd.wsel = gmr_pkg::WSEL_HOLD;
        cmd.waddr = (act_r == gmr_pkg::ActSwapCols) ? {pidx_row, c2_r} : {sr_r, pidx_col};
        state_nxt = S_RUN;
      end
      S_LAST: begin
        cmd.rd_capture = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r <= pend_nxt;
    end
    act_r <= act_nxt;
    dr_r <= dr_nxt;
    sr_r <= sr_nxt;
    c1_r <= c1_nxt;
    c2_r <= c2_nxt;
    idx_r <= idx_nxt;
    lim_r <= lim_nxt;
    pidx_r <= pidx_nxt;
  end

  assign busy = (state_r != S_IDLE);
  assign done = (state_r == S_DONE);
  assign done_action = act_r;
  assign out_zero = (act_r != gmr_pkg::ActRead);

  `GMR_ASSERT_IMP(a_no_wr_idle, clk, rst_n, state_r == S_IDLE && !start, !cmd.wen, "write while idle")
  `GMR_ASSERT_NEXT(a_done_idle, clk, rst_n, state_r == S_DONE, state_r == S_IDLE, "done not followed by idle")
  `GMR_ASSERT_NEXT(a_swb_run, clk, rst_n, state_r == S_SWB, state_r == S_RUN, "swap slot not followed by run")
  `GMR_ASSERT_IMP(a_idx_lim, clk, rst_n, state_r == S_RUN, idx_r <= lim_r, "walk index past limit")

endmodule

### sv/gf256_matrix_row_engine.sv
// GF(256) matrix row engine: one action per start, 64x64 octet memory in block RAM.
// Writes, skips and unknown actions go straight to the result cycle, reads via a capture
// state; row ops walk n active columns, swaps n columns/rows with a second write each.
// Throughput is one action at a time; the next start is taken in the cycle after the result.
// Reset (rst_n, synchronous) clears the controller state and loads the configuration defaults;
// matrix contents are undefined. out_valid pulses for one cycle; the receiver cannot stall.
module gf256_matrix_row_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  in_action,
  input  logic [5:0]  in_dst_row,
  input  logic [5:0]  in_src_row,
  input  logic [5:0]  in_col_first,
  input  logic [5:0]  in_col_second,
  input  logic [7:0]  in_value,
  output logic        out_valid,
  output logic [7:0]  out_read_data,
  output logic [3:0]  out_done_action,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [6:0] cfg_cols_r, cfg_cols_nxt;
  logic [6:0] cfg_rows_r, cfg_rows_nxt;
  logic [7:0] cfg_poly_r, cfg_poly_nxt;
  logic [7:0] value_r;
  logic [1:0] reg_idx;
  logic       cfg_wr;
  logic       out_zero;
  logic [7:0] dp_rd;
  gmr_pkg::dp_cmd_t cmd;

  assign pready = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr = psel && penable && pwrite && pready;

  // Configuration register writes.
  always_comb begin
    cfg_cols_nxt = cfg_cols_r;
    cfg_rows_nxt = cfg_rows_r;
    cfg_poly_nxt = cfg_poly_r;
    if (cfg_wr) begin
      case (reg_idx)
        gmr_pkg::RegCols: cfg_cols_nxt = pwdata[6:0];
        gmr_pkg::RegRows: cfg_rows_nxt = pwdata[6:0];
        gmr_pkg::RegPoly: cfg_poly_nxt = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_cols_r <= 7'd64;
      cfg_rows_r <= 7'd64;
      cfg_poly_r <= 8'd29;
    end else begin
      cfg_cols_r <= cfg_cols_nxt;
      cfg_rows_r <= cfg_rows_nxt;
      cfg_poly_r <= cfg_poly_nxt;
    end
    if (start && !busy) value_r <= in_value;
  end

  // Register read-back.
  always_comb begin
    case (reg_idx)
      gmr_pkg::RegCols: prdata = {25'd0, cfg_cols_r};
      gmr_pkg::RegRows: prdata = {25'd0, cfg_rows_r};
      gmr_pkg::RegPoly: prdata = {24'd0, cfg_poly_r};
      default:          prdata = 32'd0;
    endcase
  end

  gmr_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .action(in_action),
    .dst_row(in_dst_row), .src_row(in_src_row), .col_first(in_col_first),
    .col_second(in_col_second), .value(in_value), .active_cols(cfg_cols_r),
    .active_rows(cfg_rows_r), .busy(busy), .done(out_valid),
    .done_action(out_done_action), .out_zero(out_zero), .cmd(cmd)
  );

  // A write in the idle cycle uses the live value; later cycles use the latched one.
  gmr_datapath u_dp (
    .clk(clk), .cmd(cmd), .value(busy ? value_r : in_value), .poly(cfg_poly_r),
    .read_data(dp_rd)
  );

  assign out_read_data = out_zero ? 8'h00 : dp_rd;

endmodule
